[src/sdfb_pkg.sv]
package sdfb_pkg;

    localparam int DISPLAY_BYTES = 16;
    localparam int IDX_W         = $clog2(DISPLAY_BYTES);
    localparam int HEADER_WORDS  = 2;
    localparam int FLUSH_WORDS   = HEADER_WORDS + DISPLAY_BYTES;
    localparam int CATHODE_WORDS = 3;
    localparam int CNT_W         = $clog2(FLUSH_WORDS);
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [7:0] CMD_DATA_WRITE = 8'h40;
    localparam logic [7:0] CMD_ADDRESS    = 8'hC0;
    localparam logic [7:0] DP_BIT         = 8'h80;
    localparam logic [6:0] CHAR_UPPER_A   = 7'h41;
    localparam logic [6:0] CHAR_UPPER_F   = 7'h46;
    localparam logic [6:0] CHAR_LOWER_A   = 7'h61;
    localparam logic [6:0] CHAR_LOWER_F   = 7'h66;
    localparam logic [3:0] LAST_POSITION  = 4'd9;

    localparam logic [7:0] SEG_TABLE [16] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
    };

    typedef enum logic [1:0] {
        OP_CATHODE = 2'd0,
        OP_STORE   = 2'd1,
        OP_FLUSH   = 2'd2
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] pos;
        logic [7:0] seg;
    } entry_t;

    function automatic logic [7:0] hex_to_seg(input logic [7:0] code);
        logic [6:0] v;
        logic [7:0] dp;
        logic [3:0] letter;
        logic [7:0] res;
        v      = code[6:0];
        dp     = code & DP_BIT;
        letter = v[3:0] + 4'd9;
        if (v <= 7'd15)
            res = SEG_TABLE[v[3:0]] | dp;
        else if ((v >= CHAR_UPPER_A && v <= CHAR_UPPER_F) ||
                 (v >= CHAR_LOWER_A && v <= CHAR_LOWER_F))
            res = SEG_TABLE[letter] | dp;
        else
            res = 8'h00;
        return res;
    endfunction

endpackage

[src/segment_display_frame_builder_top.sv]
// Channel   Handshake           Word
// ------    ---------           ----
// config    cfg_we              cfg_wdata (common_anode)
// input     in_valid/in_ready   cmd, digit_position, digit_code, group_last
// output    out_valid/out_ready frame_byte, frame_start, frame_end, last
//
// Cathode digit: the back end dequeues it, then emits 3 output words, one per cycle while the output register is free.
// Anode digit: the back end dequeues it and updates the shadow store; a group end
// then adds 18 words, one per cycle while the output register is free.
// Output stalls hold the word counter; a two-entry queue parts intake from emission.
// Input stalls only when the queue is full.
// Reset clears mode, queue, sequencer and the 16-byte shadow store at once.
module segment_display_frame_builder_top
    import sdfb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       cmd,
    input  logic [3:0] digit_position,
    input  logic [7:0] digit_code,
    input  logic       group_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] frame_byte,
    output logic       frame_start,
    output logic       frame_end,
    output logic       last
);

    logic   wr_valid, wr_ready;
    entry_t wr_entry;
    logic   rd_valid, rd_ready;
    entry_t rd_entry;

    sdfb_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .digit_position (digit_position),
        .digit_code     (digit_code),
        .group_last     (group_last),
        .wr_valid       (wr_valid),
        .wr_ready       (wr_ready),
        .wr_entry       (wr_entry)
    );

    sdfb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .wr_entry (wr_entry),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd_entry (rd_entry)
    );

    sdfb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_valid    (rd_valid),
        .rd_ready    (rd_ready),
        .rd_entry    (rd_entry),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .frame_byte  (frame_byte),
        .frame_start (frame_start),
        .frame_end   (frame_end),
        .last        (last)
    );

endmodule

[src/sdfb_front.sv]
module sdfb_front
    import sdfb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       cmd,
    input  logic [3:0] digit_position,
    input  logic [7:0] digit_code,
    input  logic       group_last,
    output logic       wr_valid,
    input  logic       wr_ready,
    output entry_t     wr_entry
);

    logic common_anode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            common_anode_reg <= 1'b0;
        else if (cfg_we)
            common_anode_reg <= cfg_wdata;
    end

    assign in_ready = wr_ready;
    assign wr_valid = in_valid;

    always_comb
    begin
        wr_entry.pos = digit_position;
        wr_entry.seg = cmd ? hex_to_seg(digit_code) : digit_code;
        if (!common_anode_reg)
            wr_entry.op = OP_CATHODE;
        else if (group_last)
            wr_entry.op = OP_FLUSH;
        else
            wr_entry.op = OP_STORE;
    end

endmodule

[src/sdfb_queue.sv]
module sdfb_queue
    import sdfb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_valid,
    output logic   wr_ready,
    input  entry_t wr_entry,
    output logic   rd_valid,
    input  logic   rd_ready,
    output entry_t rd_entry
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    entry_t               slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]       count_reg, count_next;
    logic                 push, pop;

    assign wr_ready = (count_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_entry = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule

[src/sdfb_back.sv]
module sdfb_back
    import sdfb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rd_valid,
    output logic       rd_ready,
    input  entry_t     rd_entry,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] frame_byte,
    output logic       frame_start,
    output logic       frame_end,
    output logic       last
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    logic [3:0]       pos_reg, pos_next;
    logic [7:0]       seg_reg, seg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       shadow_reg  [DISPLAY_BYTES];
    logic [7:0]       shadow_next [DISPLAY_BYTES];

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             start_reg, start_next;
    logic             end_reg, end_next;
    logic             last_reg, last_next;

    logic             pop, store_en, emit, final_word;
    logic [7:0]       word_byte;
    logic             word_start, word_end;
    logic [CNT_W-1:0] sh_off;

    assign rd_ready = (state_reg == ST_IDLE);
    assign pop      = rd_valid && rd_ready;
    assign store_en = pop && (rd_entry.op != OP_CATHODE) && (rd_entry.pos <= LAST_POSITION);
    assign emit     = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign sh_off   = cnt_reg - CNT_W'(HEADER_WORDS);

    // transpose: segment bit k lands in bit pos[2:0] of byte 2k (+1 for positions 8..9)
    always_comb
    begin
        for (int i = 0; i < DISPLAY_BYTES; i++)
        begin
            shadow_next[i] = shadow_reg[i];
            if (store_en && (1'(i % 2) == rd_entry.pos[3]))
                shadow_next[i][rd_entry.pos[2:0]] = rd_entry.seg[i / 2];
        end
    end

    // build the current word from the op and the word counter
    always_comb
    begin
        word_byte  = 8'h00;
        word_start = 1'b0;
        word_end   = 1'b0;
        final_word = 1'b0;
        if (cnt_reg == '0)
        begin
            word_byte  = CMD_DATA_WRITE;
            word_start = 1'b1;
            word_end   = 1'b1;
        end
        else if (cnt_reg == CNT_W'(1))
        begin
            word_byte  = (op_reg == OP_CATHODE) ? (CMD_ADDRESS | {4'h0, pos_reg}) : CMD_ADDRESS;
            word_start = 1'b1;
        end
        else if (op_reg == OP_CATHODE)
        begin
            word_byte  = seg_reg;
            word_end   = 1'b1;
            final_word = 1'b1;
        end
        else
        begin
            word_byte  = shadow_reg[sh_off[IDX_W-1:0]];
            final_word = (cnt_reg == CNT_W'(FLUSH_WORDS - 1));
            word_end   = final_word;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        seg_next       = seg_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        last_next      = last_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop && rd_entry.op != OP_STORE)
                begin
                    state_next = ST_EMIT;
                    op_next    = rd_entry.op;
                    pos_next   = rd_entry.pos;
                    seg_next   = rd_entry.seg;
                    cnt_next   = '0;
                end
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    byte_next      = word_byte;
                    start_next     = word_start;
                    end_next       = word_end;
                    last_next      = final_word;
                    if (final_word)
                        state_next = ST_IDLE;
                    else
                        cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < DISPLAY_BYTES; i++)
                shadow_reg[i] <= 8'h00;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < DISPLAY_BYTES; i++)
                shadow_reg[i] <= shadow_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        pos_reg   <= pos_next;
        seg_reg   <= seg_next;
        byte_reg  <= byte_next;
        start_reg <= start_next;
        end_reg   <= end_next;
        last_reg  <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign frame_byte  = byte_reg;
    assign frame_start = start_reg;
    assign frame_end   = end_reg;
    assign last        = last_reg;

endmodule

[src/sdfb_checker.sv]
module sdfb_checker
    import sdfb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] frame_byte,
    input logic       frame_start,
    input logic       frame_end,
    input logic       last
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(last))
        else $error("output word changed while stalled");

    // the data-write command frame is a lone byte and never closes an item
    a_open_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_start && frame_end |-> frame_byte == CMD_DATA_WRITE && !last)
        else $error("start-and-end word is not the data-write command");

    // the final word of an item closes a frame and never opens one
    a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> frame_end && !frame_start)
        else $error("last word without frame end");

    // the address command follows a data-write command word directly
    a_addr_after_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && frame_start && frame_end ##1 out_valid
            |-> frame_start && !frame_end && frame_byte[7:6] == CMD_ADDRESS[7:6])
        else $error("address command missing after data-write command");

endmodule

bind segment_display_frame_builder_top sdfb_checker u_sdfb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_byte  (frame_byte),
    .frame_start (frame_start),
    .frame_end   (frame_end),
    .last        (last)
);
